// ===== src/lzp_pkg.sv =====
`default_nettype none

package lzp_pkg;

  // Default build limits for the field widths.
  localparam int DEF_MAX_OFFSET_BITS  = 16;
  localparam int DEF_MAX_LENGTH_BITS  = 8;
  localparam int DEF_MAX_LITERAL_BITS = 5;

  localparam int BYTE_W = 8;

  // Token kinds carried on the input tuser.
  localparam logic [1:0] OP_LITERAL = 2'd0;
  localparam logic [1:0] OP_MATCH   = 2'd1;
  localparam logic [1:0] OP_END     = 2'd2;
  localparam int         OP_W       = 2;

  // Input tdata layout: literal byte, match length, match offset.
  localparam int LEN_W      = 8;
  localparam int OFF_W      = 16;
  localparam int S_TDATA_W  = 32;

  // Configuration register file.
  localparam int         CFG_INDEX_W = 2;
  localparam int         CFG_DATA_W  = 5;
  localparam logic [1:0] CFG_OFFSET_BITS        = 2'd0;
  localparam logic [1:0] CFG_LENGTH_BITS        = 2'd1;
  localparam logic [1:0] CFG_LITERAL_COUNT_BITS = 2'd2;

  localparam int OFFSET_REG_W  = 5;
  localparam int LENGTH_REG_W  = 4;
  localparam int LITCNT_REG_W  = 3;

  localparam logic [OFFSET_REG_W-1:0] OFFSET_BITS_RST = 5'd12;
  localparam logic [LENGTH_REG_W-1:0] LENGTH_BITS_RST = 4'd4;
  localparam logic [LITCNT_REG_W-1:0] LITCNT_BITS_RST = 3'd3;

  // Commands from the sequencer to the bit buffer.
  typedef struct packed {
    logic load;   // append a chunk of bits
    logic pad;    // emit the partial byte zero-filled and clear
  } bb_ctl_t;

endpackage

`default_nettype wire

// ===== src/lzp_queue_ram.sv =====
`default_nettype none

module lzp_queue_ram #(
  parameter int DEPTH = 31,
  parameter int AW    = 5
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [lzp_pkg::BYTE_W-1:0] wdata,
  input  wire logic [AW-1:0]             raddr,
  output logic      [lzp_pkg::BYTE_W-1:0] rdata
);
  import lzp_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/lzp_bit_buf.sv =====
`default_nettype none

module lzp_bit_buf #(
  parameter int CW = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire lzp_pkg::bb_ctl_t           ctl,
  input  wire logic [CW-1:0]              value,
  input  wire logic [$clog2(CW+1)-1:0]    width,
  input  wire logic                       byte_ready,
  output logic                            busy,
  output logic                            byte_valid,
  output logic [lzp_pkg::BYTE_W-1:0]      byte_data
);
  import lzp_pkg::*;

  localparam int BW    = CW + BYTE_W;
  localparam int CNT_W = $clog2(BW);
  localparam int WID_W = $clog2(CW+1);

  // Pending bits sit left-aligned in sreg; cnt of them are valid, the rest are zero.
  logic [BW-1:0]    sreg, sreg_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CW-1:0]    value_l;
  logic [BW-1:0]    ext;

  assign busy       = cnt >= CNT_W'(BYTE_W);
  assign byte_valid = busy || ctl.pad;
  assign byte_data  = sreg[BW-1 -: BYTE_W];

  always_comb begin
    value_l = value << (WID_W'(CW) - width);
    ext     = {value_l, {BYTE_W{1'b0}}} >> cnt;
  end

  always_comb begin
    sreg_next = sreg;
    cnt_next  = cnt;
    if (busy) begin
      if (byte_ready) begin
        sreg_next = sreg << BYTE_W;
        cnt_next  = cnt - CNT_W'(BYTE_W);
      end
    end else if (ctl.pad) begin
      if (byte_ready) begin
        sreg_next = '0;
        cnt_next  = '0;
      end
    end else if (ctl.load) begin
      sreg_next = sreg | ext;
      cnt_next  = cnt + CNT_W'(width);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sreg <= '0;
      cnt  <= '0;
    end else begin
      sreg <= sreg_next;
      cnt  <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/lzp_byte_out.sv =====
`default_nettype none

module lzp_byte_out (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       byte_valid,
  input  wire logic [lzp_pkg::BYTE_W-1:0] byte_data,
  input  wire logic                       done,
  output logic                            room,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic      [lzp_pkg::BYTE_W-1:0] m_tdata,
  output logic                            m_tlast
);
  import lzp_pkg::*;

  // One byte is held back so that the last byte of a token can be flagged
  // once the token is known to be finished.
  logic              pend_v;
  logic [BYTE_W-1:0] pend_d;
  logic              can_take;
  logic              byte_fire;
  logic              done_fire;
  logic              load_out;

  assign can_take  = !m_tvalid || m_tready;
  assign room      = !pend_v || can_take;
  assign byte_fire = byte_valid && room;
  assign done_fire = done && room && !byte_valid;
  assign load_out  = (byte_fire || done_fire) && pend_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (byte_fire) begin
        pend_v <= 1'b1;
      end else if (done_fire) begin
        pend_v <= 1'b0;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_fire) begin
      pend_d <= byte_data;
    end
    if (load_out) begin
      m_tdata <= pend_d;
      m_tlast <= done_fire;
    end
  end

endmodule

`default_nettype wire

// ===== src/lz_token_bit_packer.sv =====
`default_nettype none

// LZ77 token bit packer.
// Tokens arrive on the s_axis channel: tuser carries the kind (literal, match
// or end of stream) and tdata carries the literal byte, match length and match
// offset. Packed stream bytes leave on m_axis, MSB first; tlast marks the final
// byte caused by one input token. Field widths are set through the cfg write
// port, which must only be written while the block is idle.
// Literals are queued in a small RAM and give no output until the run
// reaches the flush threshold or a match or end of stream arrives. A queue
// flush loads a header chunk, then for each queued byte waits for the
// registered RAM read and loads the byte once the bit buffer is free. A
// match then loads its chunk; an end of stream loads a zero chunk and then
// pads. One token is processed at a time; s_axis_tready is high only while
// the sequencer is idle.
// Synchronous reset clears the bit buffer, the queue count, the output stage
// and restores the default widths; the queue RAM needs no clearing because an
// entry is only read after it has been written.
// When the receiver stalls, the output register holds its transfer and one
// more byte waits behind it; the bit buffer and then the sequencer stall.

module lz_token_bit_packer #(
  parameter int MAX_OFFSET_BITS  = lzp_pkg::DEF_MAX_OFFSET_BITS,
  parameter int MAX_LENGTH_BITS  = lzp_pkg::DEF_MAX_LENGTH_BITS,
  parameter int MAX_LITERAL_BITS = lzp_pkg::DEF_MAX_LITERAL_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Configuration write port.
  input  wire logic                             cfg_we,
  input  wire logic [lzp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [lzp_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Token input.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: literal_byte [7:0], match_length [15:8], match_offset [31:16]
  input  wire logic [lzp_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // tuser: opcode [1:0]
  input  wire logic [lzp_pkg::OP_W-1:0]         s_axis_tuser,
  // Packed byte output.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tdata: out_byte [7:0]
  output logic      [lzp_pkg::BYTE_W-1:0]       m_axis_tdata,
  output logic                                  m_axis_tlast
);
  import lzp_pkg::*;

  // Largest chunk handed to the bit buffer: a match (length plus offset),
  // a queue header (marker plus count) or a literal byte.
  localparam int TAIL_MAX = (MAX_OFFSET_BITS > MAX_LITERAL_BITS) ?
                            MAX_OFFSET_BITS : MAX_LITERAL_BITS;
  localparam int CW       = (MAX_LENGTH_BITS + TAIL_MAX > BYTE_W) ?
                            (MAX_LENGTH_BITS + TAIL_MAX) : BYTE_W;
  localparam int WID_W    = $clog2(CW+1);
  localparam int NW_W     = $clog2(MAX_OFFSET_BITS+1);
  localparam int LW_W     = $clog2(MAX_LENGTH_BITS+1);
  localparam int SW_W     = $clog2(MAX_LITERAL_BITS+1);
  localparam int LITW     = MAX_LITERAL_BITS;
  localparam int QDEPTH   = (2**MAX_LITERAL_BITS) - 1;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HDR   = 3'd1;
  localparam logic [2:0] ST_LWAIT = 3'd2;
  localparam logic [2:0] ST_LIT   = 3'd3;
  localparam logic [2:0] ST_MATCH = 3'd4;
  localparam logic [2:0] ST_ENDZ  = 3'd5;
  localparam logic [2:0] ST_PAD   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // Configuration registers.
  logic [OFFSET_REG_W-1:0] offset_bits;
  logic [LENGTH_REG_W-1:0] length_bits;
  logic [LITCNT_REG_W-1:0] literal_count_bits;

  // Effective widths after clamping zero and oversize settings.
  logic [NW_W-1:0] nw;
  logic [LW_W-1:0] lw;
  logic [SW_W-1:0] sw;
  logic [LITW-1:0] limit;

  // Sequencer state and the token being worked on.
  logic [2:0]       state, state_next;
  logic [OP_W-1:0]  op_q, op_next;
  logic [LEN_W-1:0] len_q, len_next;
  logic [OFF_W-1:0] off_q, off_next;
  logic [LITW-1:0]  queue_count, queue_count_next;
  logic [LITW-1:0]  qcount, qcount_next;
  logic [LITW-1:0]  raddr, raddr_next;

  logic             queue_full;
  logic [LITW-1:0]  lit_count;
  logic             ram_we;
  logic [BYTE_W-1:0] rdata;

  logic [LEN_W-1:0] len_m1;
  logic [CW-1:0]    match_val;
  logic [CW-1:0]    hdr_val;
  logic [2:0]       after_flush;

  bb_ctl_t          bb_ctl;
  logic [CW-1:0]    bb_value;
  logic [WID_W-1:0] bb_width;
  logic             bb_busy;
  logic             bb_byte_valid;
  logic [BYTE_W-1:0] bb_byte;
  logic             room;
  logic             done;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits        <= OFFSET_BITS_RST;
      length_bits        <= LENGTH_BITS_RST;
      literal_count_bits <= LITCNT_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OFFSET_BITS:        offset_bits        <= cfg_data[OFFSET_REG_W-1:0];
        CFG_LENGTH_BITS:        length_bits        <= cfg_data[LENGTH_REG_W-1:0];
        CFG_LITERAL_COUNT_BITS: literal_count_bits <= cfg_data[LITCNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // A width of zero behaves as one bit; anything above the build limit is
  // held at the limit.
  always_comb begin
    if (offset_bits == '0) begin
      nw = NW_W'(1);
    end else if (int'(offset_bits) > MAX_OFFSET_BITS) begin
      nw = NW_W'(MAX_OFFSET_BITS);
    end else begin
      nw = NW_W'(offset_bits);
    end
    if (length_bits == '0) begin
      lw = LW_W'(1);
    end else if (int'(length_bits) > MAX_LENGTH_BITS) begin
      lw = LW_W'(MAX_LENGTH_BITS);
    end else begin
      lw = LW_W'(length_bits);
    end
    if (literal_count_bits == '0) begin
      sw = SW_W'(1);
    end else if (int'(literal_count_bits) > MAX_LITERAL_BITS) begin
      sw = SW_W'(MAX_LITERAL_BITS);
    end else begin
      sw = SW_W'(literal_count_bits);
    end
    limit = ~({LITW{1'b1}} << sw);
  end

  // A literal is dropped only when the queue is completely full, which the
  // flush threshold normally prevents.
  assign queue_full = queue_count == LITW'(QDEPTH);
  assign lit_count  = queue_full ? queue_count : queue_count + LITW'(1);

  // Match chunk: (length - 1) in L bits followed by the offset in N bits.
  // Header chunk: L zero bits then the low S bits of the queued count.
  always_comb begin
    len_m1    = len_q - LEN_W'(1);
    match_val = (CW'(len_m1 & ~({LEN_W{1'b1}} << lw)) << nw) |
                (CW'(off_q) & ~({CW{1'b1}} << nw));
    hdr_val   = CW'(qcount & limit);
    case (op_q)
      OP_MATCH: after_flush = ST_MATCH;
      OP_END:   after_flush = ST_ENDZ;
      default:  after_flush = ST_DONE;
    endcase
  end

  always_comb begin
    state_next       = state;
    op_next          = op_q;
    len_next         = len_q;
    off_next         = off_q;
    queue_count_next = queue_count;
    qcount_next      = qcount;
    raddr_next       = raddr;
    ram_we           = 1'b0;
    bb_ctl           = '0;
    bb_value         = '0;
    bb_width         = '0;
    done             = 1'b0;

    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_next  = s_axis_tuser;
          len_next = s_axis_tdata[15:8];
          off_next = s_axis_tdata[31:16];
          case (s_axis_tuser)
            OP_LITERAL: begin
              ram_we = !queue_full;
              if (lit_count >= limit) begin
                qcount_next      = lit_count;
                queue_count_next = '0;
                state_next       = ST_HDR;
              end else begin
                queue_count_next = lit_count;
              end
            end
            OP_MATCH, OP_END: begin
              if (queue_count != '0) begin
                qcount_next      = queue_count;
                queue_count_next = '0;
                state_next       = ST_HDR;
              end else if (s_axis_tuser == OP_MATCH) begin
                state_next = ST_MATCH;
              end else begin
                state_next = ST_ENDZ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_HDR: begin
        if (!bb_busy) begin
          bb_ctl.load = 1'b1;
          bb_value    = hdr_val;
          bb_width    = WID_W'(lw) + WID_W'(sw);
          raddr_next  = '0;
          state_next  = ST_LWAIT;
        end
      end
      ST_LWAIT: begin
        // The RAM read is registered; this state waits for its output.
        state_next = ST_LIT;
      end
      ST_LIT: begin
        if (!bb_busy) begin
          bb_ctl.load = 1'b1;
          bb_value    = CW'(rdata);
          bb_width    = WID_W'(BYTE_W);
          if (raddr == qcount - LITW'(1)) begin
            state_next = after_flush;
          end else begin
            raddr_next = raddr + LITW'(1);
            state_next = ST_LWAIT;
          end
        end
      end
      ST_MATCH: begin
        if (!bb_busy) begin
          bb_ctl.load = 1'b1;
          bb_value    = match_val;
          bb_width    = WID_W'(lw) + WID_W'(nw);
          state_next  = ST_DONE;
        end
      end
      ST_ENDZ: begin
        if (!bb_busy) begin
          bb_ctl.load = 1'b1;
          bb_value    = '0;
          bb_width    = WID_W'(lw) + WID_W'(sw);
          state_next  = ST_PAD;
        end
      end
      ST_PAD: begin
        // Emits the partial byte zero-filled, or a whole zero byte when aligned.
        if (!bb_busy) begin
          bb_ctl.pad = 1'b1;
          if (room) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!bb_busy) begin
          done = 1'b1;
          if (room) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      queue_count <= '0;
    end else begin
      state       <= state_next;
      queue_count <= queue_count_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q   <= op_next;
    len_q  <= len_next;
    off_q  <= off_next;
    qcount <= qcount_next;
    raddr  <= raddr_next;
  end

  assign s_axis_tready = state == ST_IDLE;

  lzp_queue_ram #(
    .DEPTH (QDEPTH),
    .AW    (LITW)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (queue_count),
    .wdata (s_axis_tdata[7:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  lzp_bit_buf #(
    .CW (CW)
  ) u_bits (
    .clk        (clk),
    .rst        (rst),
    .ctl        (bb_ctl),
    .value      (bb_value),
    .width      (bb_width),
    .byte_ready (room),
    .busy       (bb_busy),
    .byte_valid (bb_byte_valid),
    .byte_data  (bb_byte)
  );

  lzp_byte_out u_out (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (bb_byte_valid),
    .byte_data  (bb_byte),
    .done       (done),
    .room       (room),
    .m_tvalid   (m_axis_tvalid),
    .m_tready   (m_axis_tready),
    .m_tdata    (m_axis_tdata),
    .m_tlast    (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== src/lzp_checker.sv =====
`default_nettype none

module lzp_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic [lzp_pkg::OP_W-1:0]    s_axis_tuser,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [lzp_pkg::BYTE_W-1:0]  m_axis_tdata,
  input wire logic                        m_axis_tlast
);
  import lzp_pkg::*;

  // A stalled output transfer keeps its byte and its last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transfer changed while stalled");

  // Reset empties the output stage.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A byte that is not the last of its token means the token is still in work.
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input ready while a token's bytes are pending");

  // Matches and end of stream always start work in the sequencer, so the block goes busy.
  a_tok_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready &&
      (s_axis_tuser == OP_MATCH || s_axis_tuser == OP_END) |=> !s_axis_tready)
    else $error("input ready right after a match or end token");

endmodule

bind lz_token_bit_packer lzp_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lzp_pkg::*;

  // The fourth token kind has no meaning; the packer must drop it silently.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Literal queue depth follows from the widest run count the block supports.
  localparam int QUEUE_SLOTS = (1 << DEF_MAX_LITERAL_BITS) - 1;

  // Cycles allowed for the block to settle after the last expected byte.
  // The longest operation is a full queue flush.
  localparam int SETTLE_CYCLES = 100;

  // One input token as it travels on the slave side.
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  lit;
    logic [7:0]  len;
    logic [15:0] off;
  } token_t;

  // One packed stream byte as it leaves on the master side.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // tdata: literal_byte [7:0], match_length [15:8], match_offset [31:16]
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  // tuser: opcode [1:0]
  logic [OP_W-1:0]      s_axis_tuser  = '0;

  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // tdata: out_byte [7:0]
  logic [BYTE_W-1:0] m_axis_tdata;
  logic              m_axis_tlast;

  lz_token_bit_packer DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Random idling on either side; both are switched off for the final stretch.
  bit tx_gaps_on  = 1'b1;
  bit rx_stall_on = 1'b1;

  int errors = 0;

  // ---------------------------------------------------------------------------
  // Packer model. It keeps its own copy of the width registers, the partial
  // output byte and the literal queue, and turns each accepted token into the
  // stream bytes it should produce.
  // ---------------------------------------------------------------------------
  logic [OFFSET_REG_W-1:0] offset_reg = OFFSET_BITS_RST;
  logic [LENGTH_REG_W-1:0] length_reg = LENGTH_BITS_RST;
  logic [LITCNT_REG_W-1:0] count_reg  = LITCNT_BITS_RST;

  logic [7:0] partial_byte = '0;
  int         partial_fill = 0;
  logic [7:0] literal_fifo [QUEUE_SLOTS];
  int         literal_count = 0;

  logic [7:0]   fresh_bytes [$];
  stream_byte_t expected_bytes [$];

  // A width register of zero behaves as one; anything above the build limit
  // behaves as the limit.
  function automatic int eff_width(input int w, input int maxw);
    if (w == 0) return 1;
    if (w > maxw) return maxw;
    return w;
  endfunction

  // Append the low nbits of value, most significant first. Every completed
  // byte becomes one stream byte.
  function automatic void shift_in(input logic [31:0] value, input int nbits);
    for (int i = nbits - 1; i >= 0; i--) begin
      partial_byte = {partial_byte[6:0], value[i]};
      partial_fill++;
      if (partial_fill == 8) begin
        fresh_bytes = {fresh_bytes, partial_byte};
        partial_byte = '0;
        partial_fill = 0;
      end
    end
  endfunction

  // A literal run goes out as a zero marker of L bits, the run count in S bits
  // (only its low bits if the count width was narrowed) and then the bytes.
  function automatic void flush_literals(input int lw, input int sw);
    if (literal_count == 0) return;
    shift_in(32'd0, lw);
    shift_in(literal_count & ((1 << sw) - 1), sw);
    for (int i = 0; i < literal_count; i++)
      shift_in({24'd0, literal_fifo[i]}, 8);
    literal_count = 0;
  endfunction

  function automatic void pack_token(input token_t tok);
    int nw;
    int lw;
    int sw;
    stream_byte_t sb;
    nw = eff_width(int'(offset_reg), DEF_MAX_OFFSET_BITS);
    lw = eff_width(int'(length_reg), DEF_MAX_LENGTH_BITS);
    sw = eff_width(int'(count_reg), DEF_MAX_LITERAL_BITS);
    fresh_bytes.delete();
    case (tok.op)
      OP_LITERAL: begin
        if (literal_count < QUEUE_SLOTS) begin
          literal_fifo[literal_count] = tok.lit;
          literal_count++;
        end
        if (literal_count >= (1 << sw) - 1) flush_literals(lw, sw);
      end
      OP_MATCH: begin
        flush_literals(lw, sw);
        // A length of zero or one too long for L bits wraps modulo 2^L.
        shift_in((int'(tok.len) - 1) & ((1 << lw) - 1), lw);
        shift_in(tok.off & ((1 << nw) - 1), nw);
      end
      OP_END: begin
        flush_literals(lw, sw);
        shift_in(32'd0, lw + sw);
        // Padding always writes at least one bit, so an aligned stream gets
        // a whole zero byte.
        shift_in(32'd0, 8 - partial_fill);
      end
      default: begin
      end
    endcase
    foreach (fresh_bytes[i]) begin
      sb.data = fresh_bytes[i];
      sb.last = (i == fresh_bytes.size() - 1);
      expected_bytes = {expected_bytes, sb};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and run limit.
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  // Far above the slowest correct run.
  initial begin
    #10_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready drops at random for bursts of random length, with
  // stretches of steady ready in between.
  // ---------------------------------------------------------------------------
  initial begin : sink_ready
    int hold;
    forever begin
      @(posedge clk);
      if (rx_stall_on && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Every output transfer is compared with the oldest expected byte. Values
  // are read right after the edge, before any update made at that edge lands.
  always @(posedge clk) begin : byte_check
    stream_byte_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("out_byte %02h arrived with no byte expected", m_axis_tdata);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata !== want.data) begin
          $error("out_byte: expected %02h, actual %02h", want.data, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_of_run: expected %0b, actual %0b", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Offer one token and hold it until the block takes it. Valid stays high
  // between back-to-back tokens; it only drops for a random gap.
  task automatic send_token(input token_t tok);
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= tok.op;
    s_axis_tdata  <= {tok.off, tok.len, tok.lit};
    do @(posedge clk); while (!s_axis_tready);
    pack_token(tok);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [7:0] lit,
                         input logic [7:0] len, input logic [15:0] off);
    send_token('{op: op, lit: lit, len: len, off: off});
  endtask

  // Stop offering tokens and let the block drain. A trailing literal yields
  // no byte, so the settle time covers whatever is still in progress.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_OFFSET_BITS:        offset_reg = value;
      CFG_LENGTH_BITS:        length_reg = value[LENGTH_REG_W-1:0];
      CFG_LITERAL_COUNT_BITS: count_reg  = value[LITCNT_REG_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_widths(input int n, input int l, input int s);
    wait_idle();
    write_reg(CFG_OFFSET_BITS, CFG_DATA_W'(n));
    write_reg(CFG_LENGTH_BITS, CFG_DATA_W'(l));
    write_reg(CFG_LITERAL_COUNT_BITS, CFG_DATA_W'(s));
  endtask

  // A stream of random tokens closed by an end of stream. Well-formed tokens
  // dominate: literal runs, at most one past the flush threshold, and matches
  // whose length and offset fit the current widths. With noise enabled a tenth
  // of the tokens are unused opcodes or matches with raw, out-of-range fields.
  task automatic run_stream(input int count, input bit noisy);
    token_t tok;
    int     roll;
    int     nw;
    int     lw;
    int     sw;
    int     hi;
    int     run;
    int     sent;
    sent = 0;
    while (sent < count) begin
      nw = eff_width(int'(offset_reg), DEF_MAX_OFFSET_BITS);
      lw = eff_width(int'(length_reg), DEF_MAX_LENGTH_BITS);
      sw = eff_width(int'(count_reg), DEF_MAX_LITERAL_BITS);
      tok.lit = 8'($urandom);
      tok.len = 8'($urandom);
      tok.off = 16'($urandom);
      roll = $urandom_range(0, 99);
      if (noisy && roll < 10) begin
        tok.op = ($urandom_range(0, 1) != 0) ? OP_UNUSED : OP_MATCH;
        send_token(tok);
        sent++;
      end else if (roll < 60) begin
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1 << sw)
                                          : $urandom_range(1, 4);
        tok.op = OP_LITERAL;
        repeat (run) begin
          tok.lit = 8'($urandom);
          send_token(tok);
          sent++;
        end
      end else if (roll < 93) begin
        hi = (1 << lw) - 1;
        tok.op  = OP_MATCH;
        tok.len = (hi >= 2) ? 8'($urandom_range(2, hi)) : 8'd2;
        tok.off = 16'($urandom_range(0, (1 << nw) - 1));
        send_token(tok);
        sent++;
      end else begin
        tok.op = OP_END;
        send_token(tok);
        sent++;
      end
    end
    tok.op = OP_END;
    send_token(tok);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset widths (N=12, L=4, S=3, so a run flushes at 7 literals): extreme
  // literal bytes, a short and a long match, wrapped lengths, an offset
  // wider than N, an ignored opcode with every tdata bit set, a run up to
  // the flush threshold, and an end of stream on an aligned stream.
  task automatic test_reset_widths();
    send_op(OP_LITERAL, 8'h00, 8'h00, 16'h0000);
    send_op(OP_LITERAL, 8'hFF, 8'h00, 16'h0000);
    send_op(OP_MATCH,   8'h00, 8'd2,   16'h0000);
    send_op(OP_MATCH,   8'h00, 8'd15,  16'h0FFF);
    send_op(OP_MATCH,   8'h00, 8'd0,   16'hFFFF);
    send_op(OP_MATCH,   8'h00, 8'd255, 16'h8000);
    send_op(OP_UNUSED,  8'hFF, 8'hFF,  16'hFFFF);
    for (int i = 0; i < 7; i++)
      send_op(OP_LITERAL, 8'(8'h31 * i + 8'h5A), 8'h00, 16'h0000);
    send_op(OP_END, 8'h00, 8'h00, 16'h0000);
    send_op(OP_END, 8'h00, 8'h00, 16'h0000);
  endtask

  // Narrowest, widest and out-of-range widths, each with a short stream, and
  // L+S of exactly 8 so that an end on an aligned stream pads a whole byte.
  task automatic test_width_extremes();
    set_widths(1, 1, 1);
    run_stream(12, 1'b0);
    set_widths(16, 8, 5);
    run_stream(12, 1'b0);
    set_widths(0, 0, 0);
    run_stream(12, 1'b1);
    set_widths(31, 15, 7);
    run_stream(12, 1'b1);
    set_widths(12, 4, 4);
    send_op(OP_END, 8'h00, 8'h00, 16'h0000);
    send_op(OP_END, 8'h00, 8'h00, 16'h0000);
    run_stream(12, 1'b0);
  endtask

  // Literals pile up under a wide count, then the count width is narrowed.
  // The next literal must flush the whole queue with only the low count bits
  // in the count field. The second pass ends at a full queue.
  task automatic test_narrowed_count();
    set_widths(9, 3, 5);
    repeat (20) send_op(OP_LITERAL, 8'($urandom), 8'($urandom), 16'($urandom));
    wait_idle();
    write_reg(CFG_LITERAL_COUNT_BITS, CFG_DATA_W'(2));
    send_op(OP_LITERAL, 8'($urandom), 8'($urandom), 16'($urandom));
    send_op(OP_END, 8'h00, 8'h00, 16'h0000);
    wait_idle();
    write_reg(CFG_LITERAL_COUNT_BITS, CFG_DATA_W'(5));
    repeat (30) send_op(OP_LITERAL, 8'($urandom), 8'($urandom), 16'($urandom));
    wait_idle();
    write_reg(CFG_LITERAL_COUNT_BITS, CFG_DATA_W'(1));
    send_op(OP_LITERAL, 8'($urandom), 8'($urandom), 16'($urandom));
    send_op(OP_MATCH, 8'h00, 8'd5, 16'h01AB);
    send_op(OP_END, 8'h00, 8'h00, 16'h0000);
  endtask

  // Random widths, including out-of-range ones, each with a noisy stream.
  task automatic test_random_streams();
    repeat (4) begin
      set_widths($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 7));
      run_stream(25, 1'b1);
    end
  endtask

  // Last stretch with no idling on either side at full throughput.
  task automatic test_full_rate();
    set_widths(12, 4, 3);
    tx_gaps_on  = 1'b0;
    rx_stall_on = 1'b0;
    run_stream(30, 1'b1);
  endtask

  initial begin : main
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_widths();
    test_width_extremes();
    test_narrowed_count();
    test_random_streams();
    test_full_rate();

    // Drain, then leave time for any stray byte to show up.
    wait_idle();
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lzp_pkg.sv
src/lzp_queue_ram.sv
src/lzp_bit_buf.sv
src/lzp_byte_out.sv
src/lz_token_bit_packer.sv
src/lzp_checker.sv
bench/tb_top.sv
